// File: src/act_pkg.sv
// Shared types, codes and helpers for the address connection tracker.
// No dependencies; used by address_connection_tracker_top.
`default_nettype none

package act_pkg;

    localparam logic [31:0] HASH_MULT          = 32'h045d9f3b;
    localparam logic [15:0] REGION_COUNTRY_RST = 16'h5255;

    localparam logic CMD_CONNECT    = 1'b0;
    localparam logic CMD_DISCONNECT = 1'b1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    typedef enum logic [14:0] {
        S_CLEAR   = 15'h0001,
        S_IDLE    = 15'h0002,
        S_HASH_A  = 15'h0004,
        S_HASH_B  = 15'h0008,
        S_MOD     = 15'h0010,
        S_PRB_REQ = 15'h0020,
        S_PRB_CHK = 15'h0040,
        S_SLOT_WR = 15'h0080,
        S_CTY_REQ = 15'h0100,
        S_CTY_CHK = 15'h0200,
        S_CTY_UPD = 15'h0400,
        S_REG_REQ = 15'h0800,
        S_REG_CHK = 15'h1000,
        S_REG_UPD = 15'h2000,
        S_OUT     = 15'h4000
    } state_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] active;
        logic [31:0] total;
        logic [15:0] country;
        logic [55:0] region;
    } slot_t;

    typedef struct packed {
        logic [15:0] code;
        logic [31:0] active;
        logic [31:0] seen;
    } country_t;

    typedef struct packed {
        logic [55:0] code;
        logic [31:0] active;
        logic [31:0] seen;
    } region_t;

    function automatic logic [31:0] inc_sat(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] dec_sat(input logic [31:0] v);
        return (v == 32'd0) ? v : v - 32'd1;
    endfunction

    // Drop the first zero byte and everything below it.
    function automatic logic [55:0] cut_region(input logic [55:0] v);
        logic [55:0] r;
        logic        stop;
        r    = '0;
        stop = 1'b0;
        for (int k = 0; k < 7; k++) begin
            if (v[55-8*k -: 8] == 8'h00) stop = 1'b1;
            if (!stop) r[55-8*k -: 8] = v[55-8*k -: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/act_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module act_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: src/address_connection_tracker_top.sv
// Connection tracker: an event passes through accept, S_HASH_A, S_HASH_B, the steps of S_MOD,
// a request and a check per probe, a slot write, a request and a check per country entry
// compared plus a request to close a miss and an update, the same for regions, and S_OUT
// (held while the output word waits). No new event is accepted until the last leaves S_OUT.
// Reset (aresetn low, synchronous) starts a clearing pass over every address RAM slot; no
// word is accepted until it ends. Config writes are taken at any time except during reset.
`default_nettype none

module address_connection_tracker_top #(
    parameter int ADDR_SLOTS      = 4096,
    parameter int COUNTRY_ENTRIES = 256,
    parameter int REGION_ENTRIES  = 128
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,   // region_country
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] ip_address, [47:32] country_code, [103:48] region_code
    input  wire logic [103:0] s_tdata,
    input  wire logic [0:0]   s_tuser,       // [0] command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [0] new_address, [32:1] active_connections, [64:33] total_connections,
    // [72:65] country_slot, [73] country_valid, [105:74] country_active_ips,
    // [137:106] country_total_ips, [138] region_valid, [170:139] region_active_ips,
    // [202:171] region_total_ips, [207:203] zero
    output logic      [207:0] m_tdata,
    output logic      [1:0]   m_tuser        // [1:0] status
);

    localparam int SW  = $clog2(ADDR_SLOTS);
    localparam int RW  = SW + 1;
    localparam int NW  = $clog2(ADDR_SLOTS + 1);
    localparam int CIW = $clog2(COUNTRY_ENTRIES);
    localparam int CCW = $clog2(COUNTRY_ENTRIES + 1);
    localparam int RIW = $clog2(REGION_ENTRIES);
    localparam int RCW = $clog2(REGION_ENTRIES + 1);
    localparam int SLOT_W = $bits(act_pkg::slot_t);
    localparam int CTY_W  = $bits(act_pkg::country_t);
    localparam int REG_W  = $bits(act_pkg::region_t);
    localparam logic [31:0] RECIP   = 32'(64'h1_0000_0000 / 64'(ADDR_SLOTS));
    localparam logic [31:0] SLOTS32 = 32'(ADDR_SLOTS);

    act_pkg::state_t state_reg, state_next;
    logic             cmd_reg, cmd_next;
    logic [31:0]      ip_reg, ip_next;
    logic [15:0]      cc_reg, cc_next;
    logic [55:0]      rg_reg, rg_next;
    logic [31:0]      prod_reg, prod_next;
    logic [31:0]      div_reg, div_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [1:0]       step_reg, step_next;
    logic [SW-1:0]    idx_reg, idx_next;
    logic [NW-1:0]    n_reg, n_next;
    act_pkg::slot_t   slot_reg, slot_next;
    logic             old_zero_reg, old_zero_next;
    logic             old_one_reg, old_one_next;
    logic             fresh_reg, fresh_next;
    logic [1:0]       status_reg, status_next;
    logic             create_reg, create_next;
    logic [CCW-1:0]   ci_reg, ci_next;
    logic [CCW-1:0]   ccnt_reg, ccnt_next;
    logic [CIW-1:0]   ce_reg, ce_next;
    logic             ce_ok_reg, ce_ok_next;
    logic [31:0]      cact_reg, cact_next;
    logic [31:0]      cseen_reg, cseen_next;
    logic [RCW-1:0]   ri_reg, ri_next;
    logic [RCW-1:0]   rcnt_reg, rcnt_next;
    logic [RIW-1:0]   re_reg, re_next;
    logic             re_ok_reg, re_ok_next;
    logic [31:0]      ract_reg, ract_next;
    logic [31:0]      rseen_reg, rseen_next;
    logic [15:0]      cfg_reg, cfg_next;
    logic [207:0]     out_data_reg, out_data_next;
    logic [1:0]       out_user_reg, out_user_next;
    logic             out_valid_reg, out_valid_next;

    logic                slot_we;
    logic [SLOT_W-1:0]   slot_wdata, slot_rdata;
    act_pkg::slot_t      slot_rd;
    logic                cty_we;
    logic [CTY_W-1:0]    cty_wdata, cty_rdata;
    act_pkg::country_t   cty_rd;
    logic                rgn_we;
    logic [REG_W-1:0]    rgn_wdata, rgn_rdata;
    act_pkg::region_t    rgn_rd;

    logic [31:0]    hx;
    logic [31:0]    mul_a, mul_b;
    logic [63:0]    mul_p;
    act_pkg::slot_t base;
    logic           up_act, dn_act, need_region;
    logic [31:0]    cact_mod, cseen_mod, ract_mod, rseen_mod;

    act_ram #(.WIDTH(SLOT_W), .DEPTH(ADDR_SLOTS)) u_slot_ram (
        .aclk(aclk), .wr_en(slot_we), .wr_addr(idx_reg), .wr_data(slot_wdata),
        .rd_addr(idx_reg), .rd_data(slot_rdata)
    );

    act_ram #(.WIDTH(CTY_W), .DEPTH(COUNTRY_ENTRIES)) u_cty_ram (
        .aclk(aclk), .wr_en(cty_we), .wr_addr(ce_reg), .wr_data(cty_wdata),
        .rd_addr(ci_reg[CIW-1:0]), .rd_data(cty_rdata)
    );

    act_ram #(.WIDTH(REG_W), .DEPTH(REGION_ENTRIES)) u_rgn_ram (
        .aclk(aclk), .wr_en(rgn_we), .wr_addr(re_reg), .wr_data(rgn_wdata),
        .rd_addr(ri_reg[RIW-1:0]), .rd_data(rgn_rdata)
    );

    assign slot_rd  = act_pkg::slot_t'(slot_rdata);
    assign cty_rd   = act_pkg::country_t'(cty_rdata);
    assign rgn_rd   = act_pkg::region_t'(rgn_rdata);
    assign s_tready = (state_reg == act_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // One multiplier serves the hash and both steps of the reciprocal modulo
    assign hx    = ip_reg ^ (ip_reg >> 16);
    assign mul_a = (state_reg == act_pkg::S_HASH_A) ? hx
                 : ((step_reg == 2'd0) ? div_reg : prod_reg);
    assign mul_b = (state_reg == act_pkg::S_HASH_A) ? act_pkg::HASH_MULT
                 : ((step_reg == 2'd0) ? RECIP : SLOTS32);
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // Shared helpers for the counter updates
    assign up_act  = (cmd_reg == act_pkg::CMD_CONNECT) && old_zero_reg;
    assign dn_act  = (cmd_reg == act_pkg::CMD_DISCONNECT) && old_one_reg;
    assign need_region = (slot_reg.country == cfg_reg) && (slot_reg.region != 56'd0)
                         && ((cmd_reg == act_pkg::CMD_CONNECT) || old_one_reg);
    assign cact_mod  = up_act ? act_pkg::inc_sat(cact_reg)
                     : (dn_act ? act_pkg::dec_sat(cact_reg) : cact_reg);
    assign cseen_mod = fresh_reg ? act_pkg::inc_sat(cseen_reg) : cseen_reg;
    assign ract_mod  = up_act ? act_pkg::inc_sat(ract_reg)
                     : (dn_act ? act_pkg::dec_sat(ract_reg) : ract_reg);
    assign rseen_mod = fresh_reg ? act_pkg::inc_sat(rseen_reg) : rseen_reg;
    assign slot_wdata = (state_reg == act_pkg::S_CLEAR) ? '0 : SLOT_W'(slot_reg);
    assign cty_wdata  = {slot_reg.country, cact_mod, cseen_mod};
    assign rgn_wdata  = {slot_reg.region, ract_mod, rseen_mod};

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ip_next        = ip_reg;
        cc_next        = cc_reg;
        rg_next        = rg_reg;
        prod_next      = prod_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        slot_next      = slot_reg;
        old_zero_next  = old_zero_reg;
        old_one_next   = old_one_reg;
        fresh_next     = fresh_reg;
        status_next    = status_reg;
        create_next    = create_reg;
        ci_next        = ci_reg;
        ccnt_next      = ccnt_reg;
        ce_next        = ce_reg;
        ce_ok_next     = ce_ok_reg;
        cact_next      = cact_reg;
        cseen_next     = cseen_reg;
        ri_next        = ri_reg;
        rcnt_next      = rcnt_reg;
        re_next        = re_reg;
        re_ok_next     = re_ok_reg;
        ract_next      = ract_reg;
        rseen_next     = rseen_reg;
        cfg_next       = cfg_wr_en ? cfg_wr_data : cfg_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_valid_next = out_valid_reg && !m_tready;
        slot_we        = 1'b0;
        cty_we         = 1'b0;
        rgn_we         = 1'b0;
        base           = slot_rd;

        case (state_reg)
            act_pkg::S_CLEAR: begin
                slot_we = 1'b1;
                if (idx_reg == SW'(ADDR_SLOTS - 1)) begin
                    idx_next   = '0;
                    state_next = act_pkg::S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            act_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = s_tuser[0];
                    ip_next     = s_tdata[31:0];
                    cc_next     = s_tdata[47:32];
                    rg_next     = act_pkg::cut_region(s_tdata[103:48]);
                    fresh_next  = 1'b0;
                    ce_ok_next  = 1'b0;
                    re_ok_next  = 1'b0;
                    status_next = act_pkg::ST_DONE;
                    if (s_tdata[31:0] == 32'd0) begin
                        status_next = act_pkg::ST_IGNORED;
                        state_next  = act_pkg::S_OUT;
                    end else begin
                        state_next = act_pkg::S_HASH_A;
                    end
                end
            end
            act_pkg::S_HASH_A: begin
                prod_next  = mul_p[31:0];
                state_next = act_pkg::S_HASH_B;
            end
            act_pkg::S_HASH_B: begin
                div_next   = prod_reg ^ (prod_reg >> 16);
                step_next  = '0;
                state_next = act_pkg::S_MOD;
            end
            act_pkg::S_MOD: begin
                if (step_reg == 2'd0) begin
                    // quotient estimate, low by at most one
                    prod_next = mul_p[63:32];
                    step_next = 2'd1;
                end else if (step_reg == 2'd1) begin
                    rem_next  = RW'(div_reg - mul_p[31:0]);
                    step_next = 2'd2;
                end else begin
                    idx_next   = (rem_reg >= RW'(ADDR_SLOTS)) ? SW'(rem_reg - RW'(ADDR_SLOTS))
                                                             : rem_reg[SW-1:0];
                    n_next     = '0;
                    state_next = act_pkg::S_PRB_REQ;
                end
            end
            act_pkg::S_PRB_REQ: begin
                state_next = act_pkg::S_PRB_CHK;
            end
            act_pkg::S_PRB_CHK: begin
                if ((slot_rd.addr == ip_reg) || (slot_rd.addr == 32'd0)) begin
                    if (cmd_reg == act_pkg::CMD_CONNECT) begin
                        if (slot_rd.addr == 32'd0) begin
                            base.addr    = ip_reg;
                            base.active  = '0;
                            base.total   = '0;
                            base.country = cc_reg;
                            base.region  = rg_reg;
                        end
                        fresh_next       = (slot_rd.addr == 32'd0);
                        slot_next        = base;
                        slot_next.active = act_pkg::inc_sat(base.active);
                        slot_next.total  = act_pkg::inc_sat(base.total);
                        old_zero_next    = (base.active == 32'd0);
                        old_one_next     = (base.active == 32'd1);
                        state_next       = act_pkg::S_SLOT_WR;
                    end else if (slot_rd.addr == 32'd0) begin
                        status_next = act_pkg::ST_UNKNOWN;
                        state_next  = act_pkg::S_OUT;
                    end else begin
                        slot_next        = slot_rd;
                        slot_next.active = act_pkg::dec_sat(slot_rd.active);
                        old_zero_next    = (slot_rd.active == 32'd0);
                        old_one_next     = (slot_rd.active == 32'd1);
                        state_next       = act_pkg::S_SLOT_WR;
                    end
                end else if (n_reg == NW'(ADDR_SLOTS - 1)) begin
                    status_next = (cmd_reg == act_pkg::CMD_CONNECT) ? act_pkg::ST_FULL
                                                                      : act_pkg::ST_UNKNOWN;
                    state_next  = act_pkg::S_OUT;
                end else begin
                    n_next     = n_reg + 1'b1;
                    idx_next   = (idx_reg == SW'(ADDR_SLOTS - 1)) ? '0 : idx_reg + 1'b1;
                    state_next = act_pkg::S_PRB_REQ;
                end
            end
            act_pkg::S_SLOT_WR: begin
                slot_we     = 1'b1;
                ci_next     = '0;
                create_next = (cmd_reg == act_pkg::CMD_CONNECT) || old_one_reg;
                state_next  = act_pkg::S_CTY_REQ;
            end
            act_pkg::S_CTY_REQ: begin
                if (ci_reg == ccnt_reg) begin
                    if (create_reg && (ccnt_reg != CCW'(COUNTRY_ENTRIES))) begin
                        ce_next    = ccnt_reg[CIW-1:0];
                        ce_ok_next = 1'b1;
                        cact_next  = '0;
                        cseen_next = '0;
                        ccnt_next  = ccnt_reg + 1'b1;
                        state_next = act_pkg::S_CTY_UPD;
                    end else if (need_region) begin
                        ri_next    = '0;
                        state_next = act_pkg::S_REG_REQ;
                    end else begin
                        state_next = act_pkg::S_OUT;
                    end
                end else begin
                    state_next = act_pkg::S_CTY_CHK;
                end
            end
            act_pkg::S_CTY_CHK: begin
                if (cty_rd.code == slot_reg.country) begin
                    ce_next    = ci_reg[CIW-1:0];
                    ce_ok_next = 1'b1;
                    cact_next  = cty_rd.active;
                    cseen_next = cty_rd.seen;
                    state_next = act_pkg::S_CTY_UPD;
                end else begin
                    ci_next    = ci_reg + 1'b1;
                    state_next = act_pkg::S_CTY_REQ;
                end
            end
            act_pkg::S_CTY_UPD: begin
                cty_we     = 1'b1;
                cact_next  = cact_mod;
                cseen_next = cseen_mod;
                ri_next    = '0;
                state_next = need_region ? act_pkg::S_REG_REQ : act_pkg::S_OUT;
            end
            act_pkg::S_REG_REQ: begin
                if (ri_reg == rcnt_reg) begin
                    if (rcnt_reg != RCW'(REGION_ENTRIES)) begin
                        re_next    = rcnt_reg[RIW-1:0];
                        re_ok_next = 1'b1;
                        ract_next  = '0;
                        rseen_next = '0;
                        rcnt_next  = rcnt_reg + 1'b1;
                        state_next = act_pkg::S_REG_UPD;
                    end else begin
                        state_next = act_pkg::S_OUT;
                    end
                end else begin
                    state_next = act_pkg::S_REG_CHK;
                end
            end
            act_pkg::S_REG_CHK: begin
                if (rgn_rd.code == slot_reg.region) begin
                    re_next    = ri_reg[RIW-1:0];
                    re_ok_next = 1'b1;
                    ract_next  = rgn_rd.active;
                    rseen_next = rgn_rd.seen;
                    state_next = act_pkg::S_REG_UPD;
                end else begin
                    ri_next    = ri_reg + 1'b1;
                    state_next = act_pkg::S_REG_REQ;
                end
            end
            act_pkg::S_REG_UPD: begin
                rgn_we     = 1'b1;
                ract_next  = ract_mod;
                rseen_next = rseen_mod;
                state_next = act_pkg::S_OUT;
            end
            act_pkg::S_OUT: begin
                // hold until the previous word has left the output register
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_user_next  = status_reg;
                    if (status_reg == act_pkg::ST_DONE) begin
                        out_data_next = {5'd0,
                                         re_ok_reg ? rseen_reg : 32'd0,
                                         re_ok_reg ? ract_reg  : 32'd0,
                                         re_ok_reg,
                                         ce_ok_reg ? cseen_reg : 32'd0,
                                         ce_ok_reg ? cact_reg  : 32'd0,
                                         ce_ok_reg,
                                         ce_ok_reg ? 8'(ce_reg) : 8'd0,
                                         slot_reg.total,
                                         slot_reg.active,
                                         fresh_reg};
                    end else begin
                        out_data_next = '0;
                    end
                    state_next = act_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = act_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= act_pkg::S_CLEAR;
            idx_reg       <= '0;
            ccnt_reg      <= '0;
            rcnt_reg      <= '0;
            cfg_reg       <= act_pkg::REGION_COUNTRY_RST;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ccnt_reg      <= ccnt_next;
            rcnt_reg      <= rcnt_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        ip_reg       <= ip_next;
        cc_reg       <= cc_next;
        rg_reg       <= rg_next;
        prod_reg     <= prod_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        n_reg        <= n_next;
        slot_reg     <= slot_next;
        old_zero_reg <= old_zero_next;
        old_one_reg  <= old_one_next;
        fresh_reg    <= fresh_next;
        status_reg   <= status_next;
        create_reg   <= create_next;
        ci_reg       <= ci_next;
        ce_reg       <= ce_next;
        ce_ok_reg    <= ce_ok_next;
        cact_reg     <= cact_next;
        cseen_reg    <= cseen_next;
        ri_reg       <= ri_next;
        re_reg       <= re_next;
        re_ok_reg    <= re_ok_next;
        ract_reg     <= ract_next;
        rseen_reg    <= rseen_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

`ifndef SYNTH
    a_zero_addr_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[31:0] == 32'd0) |=> state_reg == act_pkg::S_OUT)
        else $error("zero address did not go straight to output");

    a_error_word_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != act_pkg::ST_DONE) |-> m_tdata == 208'd0)
        else $error("error status with non-zero fields");

    a_country_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == act_pkg::S_CTY_UPD |-> ccnt_reg <= CCW'(COUNTRY_ENTRIES) && ce_ok_reg)
        else $error("country update without a valid entry");

    a_region_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == act_pkg::S_REG_UPD |-> rcnt_reg <= RCW'(REGION_ENTRIES) && re_ok_reg)
        else $error("region update without a valid entry");
`endif

endmodule

`default_nettype wire
